/* rtl/core/bayer_bilinear_to_gray_macros.svh */
// ============================================================================
// Bayer-to-gray assertion macros
// Shared concurrent assertion forms for the Bayer-to-gray block.
// ============================================================================
`ifndef BAYER_BILINEAR_TO_GRAY_MACROS_SVH
`define BAYER_BILINEAR_TO_GRAY_MACROS_SVH

// Same-cycle implication on clock, disabled while reset is high.
`define BBG_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication on clock, disabled while reset is high.
`define BBG_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/core/bbg_pkg.sv */
// ============================================================================
// Bayer-to-gray package
// Types and fixed constants shared by the front end, queue and luma back end.
// ============================================================================
package bbg_pkg;

   // Configuration register indexes.
   localparam logic [1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_IMAGE_HEIGHT = 2'd1;

   // Reset values of the configuration registers.
   localparam logic [11:0] IMAGE_WIDTH_RESET  = 12'd640;
   localparam logic [15:0] IMAGE_HEIGHT_RESET = 16'd480;

   // Queue between front end and back end.
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = 2;
   localparam int QUEUE_LEVEL_W = 3;
   localparam logic [QUEUE_LEVEL_W-1:0] QUEUE_FULL_LEVEL = 3'd4;

   // BT.601 luma weights scaled by 1000, with the rounding term.
   localparam logic [17:0] LUMA_COEF_R = 18'd299;
   localparam logic [17:0] LUMA_COEF_G = 18'd587;
   localparam logic [17:0] LUMA_COEF_B = 18'd114;
   localparam logic [17:0] LUMA_ROUND  = 18'd500;

   // Division by 1000 as multiply and shift. The reciprocal is rounded up
   // and its error times the largest sum stays below 2^28, so the quotient
   // is exact for every sum under 2^18.
   localparam logic [18:0] DIV_RECIP = 19'd268436;
   localparam int DIV_SHIFT = 28;

   // Color site of the pixel at the window center.
   typedef enum logic [1:0] {
      SITE_BLUE       = 2'b00,
      SITE_GREEN_EVEN = 2'b01,
      SITE_GREEN_ODD  = 2'b10,
      SITE_RED        = 2'b11
   } site_type;

   // Per-pixel classification carried down the front end.
   typedef struct packed {
      logic     interior;
      site_type site;
      logic     row_end;
      logic     frame_end;
   } pixel_info_type;

   // Reconstructed color of one interior pixel.
   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       row_end;
      logic       frame_end;
   } color_item_type;

   // Queue occupancy seen by both sides.
   typedef struct packed {
      logic [QUEUE_LEVEL_W-1:0] level;
      logic                     not_empty;
   } queue_status_type;

endpackage

/* rtl/core/bbg_front.sv */
// ============================================================================
// Bayer-to-gray front end
// Tracks the raster position, keeps two line stores and the 3x3 window,
// classifies each pixel and reconstructs bilinear R, G and B.
// ============================================================================
module bbg_front import bbg_pkg::*; #(
   parameter int MAX_WIDTH = 2048
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [11:0]      image_width,
   input  logic [15:0]      image_height,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [7:0]       req_raw_pixel,
   input  logic             req_frame_start,
   input  queue_status_type q_status,
   output logic             push,
   output color_item_type   push_item
);

   localparam int COL_W = $clog2(MAX_WIDTH);

   logic                 accept;
   logic [COL_W-1:0]     col_last;
   logic [15:0]          row_last;
   logic [COL_W-1:0]     col_pos;
   logic [15:0]          row_pos;
   logic [COL_W-1:0]     col_ff;
   logic [COL_W-1:0]     col_in;
   logic [15:0]          row_ff;
   logic [15:0]          row_in;
   pixel_info_type       pos_info;

   logic [15:0]          line_mem [MAX_WIDTH];
   logic [15:0]          line_q_ff;
   logic                 fwd_valid_ff;
   logic [15:0]          fwd_data_ff;
   logic [15:0]          s1_entry;
   logic [7:0]           s1_top;
   logic [7:0]           s1_mid;

   logic                 s1_valid_ff;
   pixel_info_type       s1_info_ff;
   logic [7:0]           s1_pix_ff;
   logic [COL_W-1:0]     s1_col_ff;

   logic [7:0]           win_ff [3][3];

   logic                 s2_valid_ff;
   pixel_info_type       s2_info_ff;

   logic [8:0]           vert_sum;
   logic [8:0]           horz_sum;
   logic [9:0]           cross_sum;
   logic [9:0]           diag_sum;
   logic [3:0]           inflight;

   // Effective frame size: width at least 3 and saturated to the line store, height at least 3.
   always_comb begin
      if (image_width < 12'd3) begin
         col_last = COL_W'(2);
      end else if (32'(image_width) >= 32'(MAX_WIDTH)) begin
         col_last = COL_W'(MAX_WIDTH - 1);
      end else begin
         col_last = COL_W'(image_width - 12'd1);
      end
      if (image_height < 16'd3) begin
         row_last = 16'd2;
      end else begin
         row_last = image_height - 16'd1;
      end
   end

   // Accept only when every request in flight is sure of a queue slot.
   assign inflight = 4'(q_status.level) + 4'(s1_valid_ff) + 4'(s2_valid_ff);
   assign req_stall = (inflight >= 4'(QUEUE_DEPTH));
   assign accept = req_valid && !req_stall;

   // Position of this request, after frame start and out-of-range wrap.
   always_comb begin
      col_pos = req_frame_start ? '0 : col_ff;
      row_pos = req_frame_start ? '0 : row_ff;
      if (col_pos > col_last) begin
         col_pos = '0;
      end
      if (row_pos > row_last) begin
         row_pos = '0;
      end
      pos_info.interior  = (row_pos >= 16'd2) && (col_pos >= COL_W'(2));
      pos_info.site      = site_type'({~row_pos[0], ~col_pos[0]});
      pos_info.row_end   = (col_pos == col_last);
      pos_info.frame_end = (col_pos == col_last) && (row_pos == row_last);
   end

   // Next position: advance the column, wrap into the next row or frame.
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (col_pos >= col_last) begin
            col_in = '0;
            row_in = (row_pos >= row_last) ? 16'd0 : row_pos + 16'd1;
         end else begin
            col_in = col_pos + COL_W'(1);
            row_in = row_pos;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // Line stores as one memory: upper byte is row r-2, lower byte is row r-1.
   always_ff @(posedge clock) begin
      if (accept) begin
         line_q_ff <= line_mem[col_pos];
      end
      if (s1_valid_ff) begin
         line_mem[s1_col_ff] <= {s1_mid, s1_pix_ff};
      end
   end

   // Forward the write of the previous request when it hits the same column.
   always_ff @(posedge clock) begin
      if (accept) begin
         fwd_valid_ff <= s1_valid_ff && (s1_col_ff == col_pos);
         fwd_data_ff  <= {s1_mid, s1_pix_ff};
      end
   end

   assign s1_entry = fwd_valid_ff ? fwd_data_ff : line_q_ff;
   assign s1_top   = s1_entry[15:8];
   assign s1_mid   = s1_entry[7:0];

   // Stage one holds the request while its line store read completes.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_info_ff <= pos_info;
         s1_pix_ff  <= req_raw_pixel;
         s1_col_ff  <= col_pos;
      end
   end

   // The window shifts left by one column for every request.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 3; k++) begin
            for (int m = 0; m < 3; m++) begin
               win_ff[k][m] <= 8'd0;
            end
         end
      end else if (s1_valid_ff) begin
         for (int k = 0; k < 3; k++) begin
            win_ff[k][0] <= win_ff[k][1];
            win_ff[k][1] <= win_ff[k][2];
         end
         win_ff[0][2] <= s1_top;
         win_ff[1][2] <= s1_mid;
         win_ff[2][2] <= s1_pix_ff;
      end
   end

   // Stage two sees the updated window.
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         s2_info_ff <= s1_info_ff;
      end
   end

   // Neighbor sums around the window center.
   always_comb begin
      vert_sum  = 9'(win_ff[0][1]) + 9'(win_ff[2][1]);
      horz_sum  = 9'(win_ff[1][0]) + 9'(win_ff[1][2]);
      cross_sum = 10'(vert_sum) + 10'(horz_sum);
      diag_sum  = 10'(win_ff[0][0]) + 10'(win_ff[0][2])
                + 10'(win_ff[2][0]) + 10'(win_ff[2][2]);
   end

   // Bilinear reconstruction by site; averages are truncated.
   always_comb begin
      push_item.row_end   = s2_info_ff.row_end;
      push_item.frame_end = s2_info_ff.frame_end;
      unique case (s2_info_ff.site)
         SITE_RED: begin
            push_item.red   = win_ff[1][1];
            push_item.green = cross_sum[9:2];
            push_item.blue  = diag_sum[9:2];
         end
         SITE_BLUE: begin
            push_item.red   = diag_sum[9:2];
            push_item.green = cross_sum[9:2];
            push_item.blue  = win_ff[1][1];
         end
         SITE_GREEN_ODD: begin
            push_item.red   = horz_sum[8:1];
            push_item.green = win_ff[1][1];
            push_item.blue  = vert_sum[8:1];
         end
         SITE_GREEN_EVEN: begin
            push_item.red   = vert_sum[8:1];
            push_item.green = win_ff[1][1];
            push_item.blue  = horz_sum[8:1];
         end
         default: begin
            push_item.red   = 8'd0;
            push_item.green = 8'd0;
            push_item.blue  = 8'd0;
         end
      endcase
   end

   // Border pixels give no result.
   assign push = s2_valid_ff && s2_info_ff.interior;

endmodule

/* rtl/core/bbg_queue.sv */
// ============================================================================
// Bayer-to-gray color queue
// Four-entry FIFO that decouples the front end from the luma back end.
// ============================================================================
module bbg_queue import bbg_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  color_item_type   push_item,
   input  logic             pop,
   output color_item_type   head_item,
   output queue_status_type status
);

   color_item_type           entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]   wr_ptr_ff;
   logic [QUEUE_PTR_W-1:0]   rd_ptr_ff;
   logic [QUEUE_LEVEL_W-1:0] level_ff;
   logic [QUEUE_LEVEL_W-1:0] level_in;

   // Storage write at the tail.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   // Occupancy follows pushes and pops.
   always_comb begin
      level_in = level_ff;
      if (push && !pop) begin
         level_in = level_ff + QUEUE_LEVEL_W'(1);
      end else if (pop && !push) begin
         level_in = level_ff - QUEUE_LEVEL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QUEUE_PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QUEUE_PTR_W'(1);
         end
         level_ff <= level_in;
      end
   end

   assign head_item        = entry_ff[rd_ptr_ff];
   assign status.level     = level_ff;
   assign status.not_empty = (level_ff != '0);

endmodule

/* rtl/core/bbg_back.sv */
// ============================================================================
// Bayer-to-gray luma back end
// Weights R, G and B, adds the rounding term and divides by 1000, with the
// response register at its end.
// ============================================================================
module bbg_back import bbg_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  queue_status_type q_status,
   input  color_item_type   head_item,
   output logic             pop,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [7:0]       rsp_gray_value,
   output logic             rsp_row_end,
   output logic             rsp_frame_end
);

   logic        advance;
   logic        b1_valid_ff;
   logic [17:0] prod_r_ff;
   logic [17:0] prod_g_ff;
   logic [17:0] prod_b_ff;
   logic        b1_row_end_ff;
   logic        b1_frame_end_ff;
   logic        b2_valid_ff;
   logic [17:0] sum_ff;
   logic        b2_row_end_ff;
   logic        b2_frame_end_ff;
   logic [36:0] div_prod;
   logic        rsp_valid_ff;
   logic [7:0]  gray_ff;
   logic        row_end_ff;
   logic        frame_end_ff;

   // The whole back end moves unless a held response is stalled.
   assign advance = !rsp_valid_ff || !rsp_stall;
   assign pop     = advance && q_status.not_empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_valid_ff  <= 1'b0;
         b2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         b1_valid_ff  <= q_status.not_empty;
         b2_valid_ff  <= b1_valid_ff;
         rsp_valid_ff <= b2_valid_ff;
      end
   end

   // Stage one: the three weighted products.
   always_ff @(posedge clock) begin
      if (advance) begin
         prod_r_ff       <= 18'(head_item.red) * LUMA_COEF_R;
         prod_g_ff       <= 18'(head_item.green) * LUMA_COEF_G;
         prod_b_ff       <= 18'(head_item.blue) * LUMA_COEF_B;
         b1_row_end_ff   <= head_item.row_end;
         b1_frame_end_ff <= head_item.frame_end;
      end
   end

   // Stage two: weighted sum plus rounding term.
   always_ff @(posedge clock) begin
      if (advance) begin
         sum_ff          <= prod_r_ff + prod_g_ff + prod_b_ff + LUMA_ROUND;
         b2_row_end_ff   <= b1_row_end_ff;
         b2_frame_end_ff <= b1_frame_end_ff;
      end
   end

   // Stage three: divide by 1000 through the reciprocal into the response.
   assign div_prod = 37'(sum_ff) * 37'(DIV_RECIP);

   always_ff @(posedge clock) begin
      if (advance) begin
         gray_ff      <= div_prod[DIV_SHIFT +: 8];
         row_end_ff   <= b2_row_end_ff;
         frame_end_ff <= b2_frame_end_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_gray_value = gray_ff;
   assign rsp_row_end    = row_end_ff;
   assign rsp_frame_end  = frame_end_ff;

endmodule

/* rtl/core/bayer_bilinear_to_gray.sv */
// ============================================================================
// Bayer raw to gray converter
// A request passes front stages one and two, the queue and the back-end stages.
// Throughput: one request per cycle while req_stall is low, set by the line
// store taking one read and one write each cycle, and by the one-per-cycle luma pipe.
// Reset clears position counters, window and queue; the line store is not
// cleared and configuration returns to 640 by 480.
// ============================================================================
`include "bayer_bilinear_to_gray_macros.svh"

module bayer_bilinear_to_gray import bbg_pkg::*; #(
   parameter int MAX_WIDTH = 2048
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_raw_pixel,
   input  logic        req_frame_start,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_gray_value,
   output logic        rsp_row_end,
   output logic        rsp_frame_end,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   logic [11:0]      image_width_ff;
   logic [15:0]      image_height_ff;
   logic             push;
   logic             pop;
   logic             q_full;
   color_item_type   push_item;
   color_item_type   head_item;
   queue_status_type q_status;

   // Configuration registers; writes are always taken.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= IMAGE_WIDTH_RESET;
         image_height_ff <= IMAGE_HEIGHT_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH: begin
               image_width_ff <= csr_wdata[11:0];
            end
            CSR_IMAGE_HEIGHT: begin
               image_height_ff <= csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   // Front end: position, line stores, window and color reconstruction.
   bbg_front #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .image_width     (image_width_ff),
      .image_height    (image_height_ff),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_raw_pixel   (req_raw_pixel),
      .req_frame_start (req_frame_start),
      .q_status        (q_status),
      .push            (push),
      .push_item       (push_item)
   );

   // Queue between the two halves.
   bbg_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head_item (head_item),
      .status    (q_status)
   );

   // Back end: luma weighting, rounding and division.
   bbg_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_status       (q_status),
      .head_item      (head_item),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_gray_value (rsp_gray_value),
      .rsp_row_end    (rsp_row_end),
      .rsp_frame_end  (rsp_frame_end)
   );

   // Checks on the queue credit scheme and the response flags.
   assign q_full = (q_status.level == QUEUE_FULL_LEVEL);

   `BBG_ASSERT_IMPLY(a_queue_no_overflow, push && !pop, !q_full, "color queue overflow")
   `BBG_ASSERT_IMPLY(a_pop_not_empty, pop, q_status.not_empty, "pop from empty color queue")
   `BBG_ASSERT_IMPLY(a_full_stalls, q_full, req_stall, "full queue without request stall")
   `BBG_ASSERT_NEXT(a_push_lands, push, q_status.not_empty, "pushed color lost")
   `BBG_ASSERT_IMPLY(a_frame_row_end, rsp_valid && rsp_frame_end, rsp_row_end, "stray frame end")

endmodule

/* tb/bayer_bilinear_to_gray_tb.sv */
// ============================================================================
// Bayer raw to gray converter testbench
// Streams raw Bayer frames into the converter and checks every gray response against a
// bit-exact demosaic and luma predictor in this bench, or a pinned hand-typed result.
// A short table of directed pixels comes first. Random phases follow, each with its own
// frame size; idle and stall bursts are random but off in the last two phases.
// ============================================================================
module bayer_bilinear_to_gray_tb import bbg_pkg::*;;

   localparam int CLOCK_PERIOD   = 20;
   localparam int RESET_CYCLES   = 11;
   localparam int MAX_WIDTH      = 2048;
   localparam int SETTLE_CYCLES  = 16;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int MAX_REPORTED   = 50;
   localparam int RANDOM_PHASES  = 12;
   localparam int WIDE_PHASE     = 3;
   localparam int QUIET_PHASES   = 2;
   localparam int DIRECTED_ROWS  = 29;
   localparam int unsigned LUMA_SCALE = 1000;

   // Register indexes that map to no register.
   localparam logic [1:0] CSR_SPARE_2 = 2'd2;
   localparam logic [1:0] CSR_SPARE_3 = 2'd3;

   typedef struct packed {
      logic [7:0] gray;
      logic       row_end;
      logic       frame_end;
   } gray_result_type;

   // One directed pixel; a pinned row carries the result typed in by hand.
   typedef struct packed {
      logic [7:0]      pixel;
      logic            frame_start;
      logic            pinned;
      gray_result_type result;
   } directed_row_type;

   localparam gray_result_type NO_RESULT    = '0;
   localparam gray_result_type WHITE_CENTER = '{gray: 8'hFF, row_end: 1'b1, frame_end: 1'b1};
   localparam gray_result_type BLACK_CENTER = '{gray: 8'h00, row_end: 1'b1, frame_end: 1'b1};

   // A 3x3 frame has one interior pixel, a red site, finished by its last sample.
   directed_row_type directed_rows [DIRECTED_ROWS] = '{
      // Flat white frame.
      '{8'hFF, 1'b1, 1'b0, NO_RESULT},
      '{8'hFF, 1'b0, 1'b0, NO_RESULT},
      '{8'hFF, 1'b0, 1'b0, NO_RESULT},
      '{8'hFF, 1'b0, 1'b0, NO_RESULT},
      '{8'hFF, 1'b0, 1'b0, NO_RESULT},
      '{8'hFF, 1'b0, 1'b0, NO_RESULT},
      '{8'hFF, 1'b0, 1'b0, NO_RESULT},
      '{8'hFF, 1'b0, 1'b0, NO_RESULT},
      '{8'hFF, 1'b0, 1'b1, WHITE_CENTER},
      // Flat black frame entered by counter wrap alone.
      '{8'h00, 1'b0, 1'b0, NO_RESULT},
      '{8'h00, 1'b0, 1'b0, NO_RESULT},
      '{8'h00, 1'b0, 1'b0, NO_RESULT},
      '{8'h00, 1'b0, 1'b0, NO_RESULT},
      '{8'h00, 1'b0, 1'b0, NO_RESULT},
      '{8'h00, 1'b0, 1'b0, NO_RESULT},
      '{8'h00, 1'b0, 1'b0, NO_RESULT},
      '{8'h00, 1'b0, 1'b0, NO_RESULT},
      '{8'h00, 1'b0, 1'b1, BLACK_CENTER},
      // A frame abandoned after two samples, then a full frame of mixed values.
      '{8'hA5, 1'b1, 1'b0, NO_RESULT},
      '{8'h5A, 1'b0, 1'b0, NO_RESULT},
      '{8'h13, 1'b1, 1'b0, NO_RESULT},
      '{8'h37, 1'b0, 1'b0, NO_RESULT},
      '{8'hC8, 1'b0, 1'b0, NO_RESULT},
      '{8'h80, 1'b0, 1'b0, NO_RESULT},
      '{8'h01, 1'b0, 1'b0, NO_RESULT},
      '{8'hFE, 1'b0, 1'b0, NO_RESULT},
      '{8'h7F, 1'b0, 1'b0, NO_RESULT},
      '{8'h40, 1'b0, 1'b0, NO_RESULT},
      '{8'hE2, 1'b0, 1'b0, NO_RESULT}
   };

   logic        clock           = 1'b0;
   logic        reset           = 1'b1;
   logic        req_valid       = 1'b0;
   logic        req_stall;
   logic [7:0]  req_raw_pixel   = '0;
   logic        req_frame_start = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall       = 1'b0;
   logic [7:0]  rsp_gray_value;
   logic        rsp_row_end;
   logic        rsp_frame_end;
   logic        csr_valid       = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index       = '0;
   logic [15:0] csr_wdata       = '0;

   // Hand-typed result riding along with the current request.
   logic            pin_result  = 1'b0;
   gray_result_type pinned_gray = '0;

   // Predictor state: registers, two line stores, 3x3 window and position.
   logic [11:0]  width_reg  = IMAGE_WIDTH_RESET;
   logic [15:0]  height_reg = IMAGE_HEIGHT_RESET;
   logic [7:0]   row_above     [MAX_WIDTH];
   logic [7:0]   row_two_above [MAX_WIDTH];
   logic [7:0]   tap [3][3];
   int unsigned  col_next = 0;
   int unsigned  row_next = 0;

   gray_result_type gray_pending_q [$];
   int              mismatch_count   = 0;
   int              responses_seen   = 0;
   int              idle_cycles      = 0;
   int              stall_burst_left = 0;
   bit              sender_idle_on   = 1'b0;
   bit              rsp_stall_on     = 1'b0;

   bayer_bilinear_to_gray #(
      .MAX_WIDTH(MAX_WIDTH)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_raw_pixel(req_raw_pixel),
      .req_frame_start(req_frame_start),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_gray_value(rsp_gray_value),
      .rsp_row_end(rsp_row_end),
      .rsp_frame_end(rsp_frame_end),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   task automatic report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTED) begin
         $display("MISMATCH at %0t, response %0d: %s", $time, responses_seen, what);
      end
   endtask

   // Demosaic one raw sample into the window and predict the gray response
   // of the pixel one row up and one column left, if that pixel is interior.
   task automatic predict_gray(input logic [7:0] pix, input logic fs,
                               output bit produced, output gray_result_type res);
      int unsigned w_eff, h_eff, r, c, i, j, ctr, vs, hs, ds, rv, gv, bv;
      logic [7:0] top, mid;
      site_type site;
      w_eff = (width_reg < 3) ? 3 : (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
      h_eff = (height_reg < 3) ? 3 : height_reg;
      if (fs) begin
         col_next = 0;
         row_next = 0;
      end
      if (col_next >= w_eff) col_next = 0;
      if (row_next >= h_eff) row_next = 0;
      r = row_next;
      c = col_next;

      // Line stores shift down by one row at this column.
      top = row_two_above[c];
      mid = row_above[c];
      row_two_above[c] = mid;
      row_above[c] = pix;

      for (int k = 0; k < 3; k++) begin
         tap[k][0] = tap[k][1];
         tap[k][1] = tap[k][2];
      end
      tap[0][2] = top;
      tap[1][2] = mid;
      tap[2][2] = pix;

      produced = 1'b0;
      res = '0;
      if (r >= 2 && c >= 2) begin
         i = r - 1;
         j = c - 1;
         ctr = tap[1][1];
         vs = tap[0][1] + tap[2][1];
         hs = tap[1][0] + tap[1][2];
         ds = tap[0][0] + tap[0][2] + tap[2][0] + tap[2][2];
         site = site_type'({i[0], j[0]});
         case (site)
            SITE_RED: begin
               rv = ctr;
               gv = (vs + hs) / 4;
               bv = ds / 4;
            end
            SITE_BLUE: begin
               rv = ds / 4;
               gv = (vs + hs) / 4;
               bv = ctr;
            end
            SITE_GREEN_ODD: begin
               rv = hs / 2;
               gv = ctr;
               bv = vs / 2;
            end
            SITE_GREEN_EVEN: begin
               rv = vs / 2;
               gv = ctr;
               bv = hs / 2;
            end
         endcase
         res.gray = 8'((rv * LUMA_COEF_R + gv * LUMA_COEF_G + bv * LUMA_COEF_B
                        + LUMA_ROUND) / LUMA_SCALE);
         res.row_end = (c == w_eff - 1);
         res.frame_end = (c == w_eff - 1) && (r == h_eff - 1);
         produced = 1'b1;
      end

      if (c + 1 >= w_eff) begin
         col_next = 0;
         row_next = (r + 1 >= h_eff) ? 0 : r + 1;
      end else begin
         col_next = c + 1;
      end
   endtask

   // Register writes, requests and responses, all seen at the rising edge.
   always @(posedge clock) begin : track_handshakes
      gray_result_type due;
      gray_result_type predicted;
      bit produced;
      if (!reset) begin
         if (csr_valid && csr_ready === 1'b1) begin
            case (csr_index)
               CSR_IMAGE_WIDTH:  width_reg = csr_wdata[11:0];
               CSR_IMAGE_HEIGHT: height_reg = csr_wdata;
               default: ;
            endcase
         end
         if (rsp_valid === 1'b1 && !rsp_stall) begin
            responses_seen++;
            if (gray_pending_q.size() == 0) begin
               report_mismatch($sformatf("response gray %0d with none expected",
                                         rsp_gray_value));
            end else begin
               due = gray_pending_q.pop_front();
               if (rsp_gray_value !== due.gray)
                  report_mismatch($sformatf("gray_value %0d, expected %0d",
                                            rsp_gray_value, due.gray));
               if (rsp_row_end !== due.row_end)
                  report_mismatch($sformatf("row_end %b, expected %b",
                                            rsp_row_end, due.row_end));
               if (rsp_frame_end !== due.frame_end)
                  report_mismatch($sformatf("frame_end %b, expected %b",
                                            rsp_frame_end, due.frame_end));
            end
         end
         if (req_valid && req_stall === 1'b0) begin
            predict_gray(req_raw_pixel, req_frame_start, produced, predicted);
            if (pin_result) gray_pending_q.push_back(pinned_gray);
            else if (produced) gray_pending_q.push_back(predicted);
         end
      end
   end

   // Receiver stalls in random bursts while stalls are switched on.
   always @(negedge clock) begin
      if (!rsp_stall_on) begin
         stall_burst_left = 0;
         rsp_stall <= 1'b0;
      end else if (stall_burst_left > 0) begin
         stall_burst_left--;
         rsp_stall <= 1'b1;
      end else if ($urandom_range(0, 7) == 0) begin
         stall_burst_left = $urandom_range(0, 18);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Ends the run when no handshake of any kind happens for too long.
   initial begin
      @(negedge reset);
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_stall === 1'b0) || (rsp_valid === 1'b1 && !rsp_stall)
             || (csr_valid && csr_ready === 1'b1)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
      $display("Watchdog: no handshake for %0d cycles, %0d responses outstanding",
               WATCHDOG_LIMIT, gray_pending_q.size());
      $display("Test completed with failures");
      $finish;
   end

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_pixel(input logic [7:0] pix, input logic fs, input logic pin,
                             input gray_result_type pinned);
      int gap;
      gap = (sender_idle_on && $urandom_range(0, 9) == 0) ? $urandom_range(1, 19) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_raw_pixel <= pix;
      req_frame_start <= fs;
      pin_result <= pin;
      pinned_gray <= pinned;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [15:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (csr_ready !== 1'b1) @(posedge clock);
      @(negedge clock);
   endtask

   // Frame size for the next phase, plus a write to an unmapped index
   // that must leave both registers alone.
   task automatic set_frame_size(input logic [15:0] width_data, input logic [15:0] height_data);
      write_csr(CSR_IMAGE_WIDTH, width_data);
      write_csr(CSR_IMAGE_HEIGHT, height_data);
      write_csr($urandom_range(0, 1) ? CSR_SPARE_2 : CSR_SPARE_3, 16'($urandom));
      csr_valid <= 1'b0;
   endtask

   // Waits for every predicted response, then for the pipe to go quiet.
   task automatic wait_for_gray_drain();
      while (gray_pending_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   initial begin
      int unsigned width_pick;
      int unsigned height_pick;
      int          pixel_count;
      bit          wide;
      foreach (tap[a, b]) tap[a][b] = '0;
      foreach (row_above[n]) begin
         row_above[n] = '0;
         row_two_above[n] = '0;
      end

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part: widths and heights below three both saturate to three.
      sender_idle_on = 1'b1;
      rsp_stall_on = 1'b1;
      set_frame_size(16'hF002, 16'h0001);
      foreach (directed_rows[n]) begin
         send_pixel(directed_rows[n].pixel, directed_rows[n].frame_start,
                    directed_rows[n].pinned, directed_rows[n].result);
      end
      req_valid <= 1'b0;
      wait_for_gray_drain();

      // Random phases, each a fresh frame size; the last ones run flat out.
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         wide = (phase == WIDE_PHASE);
         if (wide) begin
            width_pick = $urandom_range(100, 160);
            height_pick = 16'hFFFF;
            pixel_count = int'(2 * width_pick + 40);
         end else begin
            case ($urandom_range(0, 9))
               0:       width_pick = $urandom_range(0, 2);
               1:       width_pick = $urandom_range(9, 40);
               default: width_pick = $urandom_range(3, 8);
            endcase
            case ($urandom_range(0, 9))
               0:       height_pick = $urandom_range(0, 2);
               1:       height_pick = 16'hFFFF;
               default: height_pick = $urandom_range(3, 8);
            endcase
            pixel_count = $urandom_range(50, 90);
         end
         set_frame_size({4'($urandom_range(0, 15)), 12'(width_pick)}, 16'(height_pick));

         sender_idle_on = (phase < RANDOM_PHASES - QUIET_PHASES) && $urandom_range(0, 3) != 0;
         rsp_stall_on = (phase < RANDOM_PHASES - QUIET_PHASES) && $urandom_range(0, 3) != 0;

         // Random pixels from a frame start; now and then a restart cuts a frame short, except in the wide phase.
         for (int n = 0; n < pixel_count; n++) begin
            send_pixel(8'($urandom_range(0, 255)),
                       (n == 0) || (!wide && $urandom_range(0, 63) == 0), 1'b0, NO_RESULT);
         end
         req_valid <= 1'b0;
         wait_for_gray_drain();
      end

      if (mismatch_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
